// File: hdl/minimum_covering_window_defines.svh
// Assertion helpers shared by the RTL of the covering window block.
// Both expect signals named clk and rst_n in the scope of use.
`ifndef MINIMUM_COVERING_WINDOW_DEFINES_SVH
`define MINIMUM_COVERING_WINDOW_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MCW_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/mcw_pkg.sv
package mcw_pkg;

    // Default text capacity in bytes
    localparam int TEXT_MAX_DEF = 4096;

    // Fixed field widths
    localparam int CH_W    = 8;
    localparam int SYMS    = 1 << CH_W;
    localparam int START_W = 12;
    localparam int LEN_W   = 13;

    // Command codes
    localparam logic CMD_PATTERN = 1'b0;
    localparam logic CMD_TEXT    = 1'b1;

endpackage

// File: hdl/mcw_if.sv
// Input transaction: one pattern or text byte
interface mcw_item_if;
    logic                      valid;
    logic                      ready;
    logic                      cmd;
    logic [mcw_pkg::CH_W-1:0]  ch;
    logic                      last;

    modport source (output valid, cmd, ch, last, input ready);
    modport sink   (input valid, cmd, ch, last, output ready);
endinterface

// Output transaction: result of one job
interface mcw_result_if;
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic [mcw_pkg::START_W-1:0]  start_res;
    logic [mcw_pkg::LEN_W-1:0]    length;
    logic                         overflow;

    modport source (output valid, found, start_res, length, overflow, input ready);
    modport sink   (input valid, found, start_res, length, overflow, output ready);
endinterface

// File: hdl/mcw_balance_mem.sv
module mcw_balance_mem #(
    parameter int DATA_W = 14
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             clear,
    input  logic [mcw_pkg::CH_W-1:0]         rd_addr,
    output logic signed [DATA_W-1:0]         rd_data,
    input  logic                             we,
    input  logic [mcw_pkg::CH_W-1:0]         wr_addr,
    input  logic signed [DATA_W-1:0]         wr_data
);

    logic signed [DATA_W-1:0] mem [mcw_pkg::SYMS];
    logic [mcw_pkg::SYMS-1:0] valid_reg;
    logic signed [DATA_W-1:0] rd_q_reg;
    logic                     rd_vld_reg;
    logic                     bypass;

    assign bypass = we && (wr_addr == rd_addr);

    // Write port and registered read, write-first on the same entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (bypass)
        begin
            rd_q_reg <= wr_data;
        end
        else
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    // Track written entries; clear drops the whole table at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= valid_reg[rd_addr] || bypass;
            if (clear)
            begin
                valid_reg <= '0;
            end
            else if (we)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // Unwritten entries read as zero
    assign rd_data = rd_vld_reg ? rd_q_reg : '0;

endmodule

// File: hdl/mcw_text_mem.sv
module mcw_text_mem #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  logic [mcw_pkg::CH_W-1:0]  wr_data,
    input  logic [ADDR_W-1:0]         rd_addr,
    output logic [mcw_pkg::CH_W-1:0]  rd_data
);

    logic [mcw_pkg::CH_W-1:0] mem [DEPTH];

    // Single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: hdl/minimum_covering_window.sv
// Shortest text window covering a pattern.
// Channel items (sink): cmd selects a pattern byte (load) or a text byte
// (scan); ch is the byte; last marks the final text byte of a job.
// Channel result (source): one transaction per job, sent after the text
// byte with last set: found, start_res, length and overflow.
// Steps per item: a pattern byte is accepted and then updated, and so is a
// text byte dropped past capacity. A stored text byte is accepted, updated
// and checked, with a head and a balance step for each window start step
// that is examined (every byte that leaves the window, plus one final look
// unless the start reaches the current byte). Each examination is a
// registered text memory read followed by a registered balance memory read;
// over a job the start advances at most once per byte. The byte with last
// adds a final step that loads the result register.
// The result register sits apart from the input: new items are taken
// while a result waits; if the receiver stalls and a second job finishes,
// the block holds in its final step until the first result is taken.
// Reset clears all control state and the balance table at once; the
// text memory needs no clearing. After a result is queued the block
// clears itself for the next job in the same cycle.
`include "minimum_covering_window_defines.svh"

module minimum_covering_window #(
    parameter int TEXT_MAX = mcw_pkg::TEXT_MAX_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    mcw_item_if.sink             items,
    mcw_result_if.source         result
);

    localparam int POS_W = $clog2(TEXT_MAX);
    localparam int CNT_W = $clog2(TEXT_MAX + 1);
    localparam int BAL_W = CNT_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPD,
        ST_HEAD,
        ST_BAL,
        ST_CHECK,
        ST_FIN
    } state_t;

    state_t                      state_reg, state_next;
    logic                        cmd_reg;
    logic [mcw_pkg::CH_W-1:0]    ch_reg;
    logic                        last_reg;
    logic [CNT_W-1:0]            uncovered_reg, uncovered_next;
    logic                        nonempty_reg, nonempty_next;
    logic [POS_W-1:0]            ws_reg, ws_next;
    logic [POS_W-1:0]            pos_reg, pos_next;
    logic [CNT_W-1:0]            text_count_reg, text_count_next;
    logic [POS_W-1:0]            best_start_reg, best_start_next;
    logic [CNT_W-1:0]            best_len_reg, best_len_next;
    logic                        ovf_reg, ovf_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        found_reg, found_next;
    logic [mcw_pkg::START_W-1:0] start_out_reg, start_out_next;
    logic [mcw_pkg::LEN_W-1:0]   len_out_reg, len_out_next;
    logic                        ovf_out_reg, ovf_out_next;

    logic                        accept;
    logic                        fin_go;
    logic                        text_room;
    logic [POS_W-1:0]            ws_inc;
    logic [CNT_W-1:0]            win_len;

    logic                        bal_clear;
    logic [mcw_pkg::CH_W-1:0]    bal_rd_addr;
    logic signed [BAL_W-1:0]     bal_rd_data;
    logic                        bal_we;
    logic [mcw_pkg::CH_W-1:0]    bal_wr_addr;
    logic signed [BAL_W-1:0]     bal_wr_data;

    logic                        txt_we;
    logic [POS_W-1:0]            txt_rd_addr;
    logic [mcw_pkg::CH_W-1:0]    txt_rd_data;

    mcw_balance_mem #(
        .DATA_W (BAL_W)
    ) u_balance (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (bal_clear),
        .rd_addr (bal_rd_addr),
        .rd_data (bal_rd_data),
        .we      (bal_we),
        .wr_addr (bal_wr_addr),
        .wr_data (bal_wr_data)
    );

    mcw_text_mem #(
        .DEPTH  (TEXT_MAX),
        .ADDR_W (POS_W)
    ) u_text (
        .clk     (clk),
        .we      (txt_we),
        .wr_addr (text_count_reg[POS_W-1:0]),
        .wr_data (items.ch),
        .rd_addr (txt_rd_addr),
        .rd_data (txt_rd_data)
    );

    assign items.ready      = (state_reg == ST_IDLE);
    assign accept           = items.valid && items.ready;
    assign text_room        = text_count_reg < CNT_W'(TEXT_MAX);
    assign fin_go           = !out_valid_reg || result.ready;
    assign ws_inc           = ws_reg + POS_W'(1);
    assign win_len          = CNT_W'(pos_reg) - CNT_W'(ws_reg) + CNT_W'(1);

    // Store the text byte as soon as it is accepted, if there is room
    assign txt_we      = accept && (items.cmd == mcw_pkg::CMD_TEXT) && text_room;
    assign txt_rd_addr = (state_reg == ST_BAL) ? ws_inc : ws_reg;

    // Balance read: the incoming byte, or the byte at the window start
    assign bal_rd_addr = (state_reg == ST_HEAD) ? txt_rd_data : items.ch;
    assign bal_clear   = (state_reg == ST_FIN) && fin_go;

    assign result.valid     = out_valid_reg;
    assign result.found     = found_reg;
    assign result.start_res = start_out_reg;
    assign result.length    = len_out_reg;
    assign result.overflow  = ovf_out_reg;

    // Sequencer: read, modify and write back the balance table
    always_comb
    begin
        state_next      = state_reg;
        uncovered_next  = uncovered_reg;
        nonempty_next   = nonempty_reg;
        ws_next         = ws_reg;
        pos_next        = pos_reg;
        text_count_next = text_count_reg;
        best_start_next = best_start_reg;
        best_len_next   = best_len_reg;
        ovf_next        = ovf_reg;
        out_valid_next  = out_valid_reg;
        found_next      = found_reg;
        start_out_next  = start_out_reg;
        len_out_next    = len_out_reg;
        ovf_out_next    = ovf_out_reg;
        bal_we          = 1'b0;
        bal_wr_addr     = ch_reg;
        bal_wr_data     = bal_rd_data;

        // Drop the result once the receiver takes it
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_UPD;
                end
            end

            ST_UPD:
            begin
                if (cmd_reg == mcw_pkg::CMD_PATTERN)
                begin
                    // Pattern bytes only count before any text
                    if (text_count_reg == '0)
                    begin
                        if (uncovered_reg >= CNT_W'(TEXT_MAX))
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            bal_we         = 1'b1;
                            bal_wr_data    = bal_rd_data - BAL_W'(1);
                            uncovered_next = uncovered_reg + CNT_W'(1);
                            nonempty_next  = 1'b1;
                        end
                    end
                    state_next = ST_IDLE;
                end
                else if (!text_room)
                begin
                    ovf_next   = 1'b1;
                    state_next = last_reg ? ST_FIN : ST_IDLE;
                end
                else
                begin
                    // Add the byte to the window
                    if (bal_rd_data < 0 && uncovered_reg != '0)
                    begin
                        uncovered_next = uncovered_reg - CNT_W'(1);
                    end
                    bal_we          = 1'b1;
                    bal_wr_data     = bal_rd_data + BAL_W'(1);
                    pos_next        = text_count_reg[POS_W-1:0];
                    text_count_next = text_count_reg + CNT_W'(1);
                    if (ws_reg < text_count_reg[POS_W-1:0])
                    begin
                        state_next = ST_HEAD;
                    end
                    else
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end

            ST_HEAD:
            begin
                // Text byte at the window start arrives; its balance is read
                state_next = ST_BAL;
            end

            ST_BAL:
            begin
                // Advance the start past a surplus byte
                if (bal_rd_data > 0)
                begin
                    bal_we      = 1'b1;
                    bal_wr_addr = txt_rd_data;
                    bal_wr_data = bal_rd_data - BAL_W'(1);
                    ws_next     = ws_inc;
                    state_next  = (ws_inc < pos_reg) ? ST_HEAD : ST_CHECK;
                end
                else
                begin
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                // Record a strictly shorter covering window
                if (nonempty_reg && uncovered_reg == '0)
                begin
                    if (best_len_reg == '0 || win_len < best_len_reg)
                    begin
                        best_len_next   = win_len;
                        best_start_next = ws_reg;
                    end
                end
                state_next = last_reg ? ST_FIN : ST_IDLE;
            end

            ST_FIN:
            begin
                // Hold until the result register is free, then clear the job
                if (fin_go)
                begin
                    out_valid_next  = 1'b1;
                    found_next      = (best_len_reg != '0);
                    start_out_next  = mcw_pkg::START_W'(best_start_reg);
                    len_out_next    = mcw_pkg::LEN_W'(best_len_reg);
                    ovf_out_next    = ovf_reg;
                    uncovered_next  = '0;
                    nonempty_next   = 1'b0;
                    ws_next         = '0;
                    text_count_next = '0;
                    best_start_next = '0;
                    best_len_next   = '0;
                    ovf_next        = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            uncovered_reg  <= '0;
            nonempty_reg   <= 1'b0;
            ws_reg         <= '0;
            pos_reg        <= '0;
            text_count_reg <= '0;
            best_start_reg <= '0;
            best_len_reg   <= '0;
            ovf_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            uncovered_reg  <= uncovered_next;
            nonempty_reg   <= nonempty_next;
            ws_reg         <= ws_next;
            pos_reg        <= pos_next;
            text_count_reg <= text_count_next;
            best_start_reg <= best_start_next;
            best_len_reg   <= best_len_next;
            ovf_reg        <= ovf_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Latch the accepted item and the result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= items.cmd;
            ch_reg   <= items.ch;
            last_reg <= items.last;
        end
        found_reg     <= found_next;
        start_out_reg <= start_out_next;
        len_out_reg   <= len_out_next;
        ovf_out_reg   <= ovf_out_next;
    end

    `MCW_ASSERT_SAME(a_start_behind_pos, state_reg == ST_BAL, ws_reg < pos_reg,
        "window start reached the current byte")
    `MCW_ASSERT_SAME(a_best_needs_pattern, best_len_reg != '0, nonempty_reg,
        "window recorded without a pattern")
    `MCW_ASSERT_SAME(a_count_bound, 1'b1, text_count_reg <= CNT_W'(TEXT_MAX),
        "text count past capacity")
    `MCW_ASSERT_SAME(a_result_from_fin, $rose(result.valid), $past(state_reg == ST_FIN),
        "result raised outside the final step")
    `MCW_ASSERT_NEXT(a_job_cleared, state_reg == ST_FIN && fin_go,
        text_count_reg == '0 && uncovered_reg == '0 && best_len_reg == '0,
        "job state not cleared after result")

endmodule
